FILE: rtl/core/binary_frame_receiver_top_defines.svh
// Assertion macros shared by the frame receiver RTL.
// Both forms sample on clk and are off while arst_n is low.
`ifndef BINARY_FRAME_RECEIVER_TOP_DEFINES_SVH
`define BINARY_FRAME_RECEIVER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BFR_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame receiver check failed");
`define BFR_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame receiver check failed");
`else
`define BFR_ASSERT_IMP(name, ante, cons)
`define BFR_ASSERT_NXT(name, ante, cons)
`endif

`endif

FILE: rtl/core/bfr_pkg.sv
`default_nettype none

package bfr_pkg;

	localparam logic [7:0] START_FIRST_RST  = 8'hAA;
	localparam logic [7:0] START_SECOND_RST = 8'h55;
	localparam logic [7:0] MAX_LEN_RST      = 8'd10;

	// a 4-bit byte counter bounds the frame at 15 bytes
	localparam logic [7:0] LEN_CAP = 8'd11;

	localparam logic [7:0] ID_BASE_CONTROL = 8'h01;
	localparam logic [7:0] ID_CTRL_QUERY   = 8'h0E;
	localparam logic [7:0] ID_EXT_DATA     = 8'h09;

	// byte positions within a frame
	localparam logic [3:0] IDX_AFTER_FIRST  = 4'd1;
	localparam logic [3:0] IDX_AFTER_SECOND = 4'd2;
	localparam logic [3:0] HDR_BYTES        = 4'd3;  // two start bytes + length
	localparam logic [3:0] POS_ID           = 4'd3;
	localparam logic [3:0] POS_FIELD0       = 4'd5;
	localparam int         FIELD_CNT        = 4;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		PH_CLEAR,
		PH_START,
		PH_LEN,
		PH_PAYLOAD
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_FIRST,
		CFG_START_SECOND,
		CFG_MAX_LEN
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_OTHER,
		KIND_BASE_CONTROL,
		KIND_CTRL_QUERY,
		KIND_EXT_DATA
	} kind_t;

	typedef struct packed {
		logic [7:0] sb_first;
		logic [7:0] sb_second;
		logic [7:0] max_len;
	} cfg_t;

	typedef struct packed {
		logic               frame_done;
		logic               frame_dropped;
		logic [7:0]         frame_id;
		kind_t              request_kind;
		logic signed [15:0] speed_value;
		logic signed [15:0] radius_value;
		logic [7:0]         ext_flag;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/core/bfr_cfg_regs.sv
`default_nettype none

module bfr_cfg_regs import bfr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [7:0]           wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sb_first  <= START_FIRST_RST;
			cfg_q.sb_second <= START_SECOND_RST;
			cfg_q.max_len   <= MAX_LEN_RST;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_START_FIRST:  cfg_q.sb_first  <= wr_data;
				CFG_START_SECOND: cfg_q.sb_second <= wr_data;
				CFG_MAX_LEN:      cfg_q.max_len   <= wr_data;
				default: ;  // unknown index: ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/bfr_parser.sv
`default_nettype none

module bfr_parser import bfr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	input  wire cfg_t       cfg,
	output res_t            res
);

	phase_t                      phase_q, phase_nxt, ph_eff;
	logic [3:0]                  idx_q, idx_nxt, idx_eff;
	logic [7:0]                  plen_q, plen_nxt;
	logic [7:0]                  id_q, id_nxt, id_eff;
	logic [FIELD_CNT-1:0][7:0]   fields_q, fields_nxt, fields_eff;
	logic                        first_q, first_nxt, first_eff;
	logic                        clr, over, last, sf_hit, ss_hit;
	logic                        done, dropped;

	// a pending clear wipes the capture state before this byte is looked at
	assign clr        = (phase_q == PH_CLEAR);
	assign ph_eff     = clr ? PH_START : phase_q;
	assign first_eff  = clr ? 1'b0 : first_q;
	assign idx_eff    = clr ? 4'd0 : idx_q;
	assign id_eff     = clr ? 8'd0 : id_q;
	assign fields_eff = clr ? '0 : fields_q;

	assign sf_hit = (rx_byte == cfg.sb_first);
	assign ss_hit = (rx_byte == cfg.sb_second);
	assign over   = (plen_q > cfg.max_len) || (plen_q > LEN_CAP);
	assign last   = ({5'd0, idx_eff} >= ({1'b0, plen_q} + 9'(HDR_BYTES)));

	always_comb begin
		phase_nxt = ph_eff;
		unique case (ph_eff)
			PH_CLEAR:   phase_nxt = PH_START;
			PH_START:   if (first_eff && ss_hit) phase_nxt = PH_LEN;
			PH_LEN:     phase_nxt = PH_PAYLOAD;
			PH_PAYLOAD: if (over || last) phase_nxt = PH_CLEAR;
			default:    phase_nxt = PH_CLEAR;
		endcase
	end

	always_comb begin
		idx_nxt    = idx_eff;
		plen_nxt   = plen_q;
		id_nxt     = id_eff;
		fields_nxt = fields_eff;
		first_nxt  = first_eff;
		done       = 1'b0;
		dropped    = 1'b0;
		unique case (ph_eff)
			PH_START: begin
				if (!first_eff) begin
					first_nxt = sf_hit;
					idx_nxt   = sf_hit ? IDX_AFTER_FIRST : 4'd0;
				end else begin
					first_nxt = 1'b0;
					idx_nxt   = ss_hit ? IDX_AFTER_SECOND : 4'd0;
				end
			end
			PH_LEN: begin
				plen_nxt = rx_byte;
				idx_nxt  = HDR_BYTES;
			end
			PH_PAYLOAD: begin
				if (idx_eff == POS_ID) id_nxt = rx_byte;
				for (int i = 0; i < FIELD_CNT; i++) begin
					if (idx_eff == POS_FIELD0 + 4'(i)) fields_nxt[i] = rx_byte;
				end
				idx_nxt = idx_eff + 4'd1;
				dropped = over;
				done    = !over && last;
			end
			default: ;
		endcase
	end

	// decode works on the capture including this byte (zero length: id is the checksum)
	always_comb begin
		res               = '0;
		res.frame_done    = done;
		res.frame_dropped = dropped;
		if (done) begin
			res.frame_id = id_nxt;
			priority if (id_nxt == ID_BASE_CONTROL) begin
				res.request_kind = KIND_BASE_CONTROL;
				res.speed_value  = {fields_nxt[1], fields_nxt[0]};
				res.radius_value = {fields_nxt[3], fields_nxt[2]};
			end else if (id_nxt == ID_CTRL_QUERY) begin
				res.request_kind = KIND_CTRL_QUERY;
			end else if (id_nxt == ID_EXT_DATA) begin
				res.request_kind = KIND_EXT_DATA;
				res.ext_flag     = fields_nxt[0];
			end else begin
				res.request_kind = KIND_OTHER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_CLEAR;
			idx_q    <= 4'd0;
			plen_q   <= 8'd0;
			id_q     <= 8'd0;
			fields_q <= '0;
			first_q  <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_nxt;
			idx_q    <= idx_nxt;
			plen_q   <= plen_nxt;
			id_q     <= id_nxt;
			fields_q <= fields_nxt;
			first_q  <= first_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/binary_frame_receiver_top.sv
// Byte-serial frame receiver.
// rx channel (rx_valid / rx_stall / rx_byte) takes one received byte per beat.
// res channel (res_valid / res_stall) returns exactly one result beat per byte:
// frame_done or frame_dropped flags plus the decoded id, kind, speed, radius
// and ext flag of a completed frame (all zero otherwise).
// cfg channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the two
// start bytes and the payload length limit; cfg_ready is always high. Write
// only while no byte is in flight.
// Throughput is one byte per cycle while res_stall is low: the byte register
// feeds the parse and decode logic, which loads the result register in the
// same cycle. An rx beat reaches res via the byte and result registers.
// When res_stall is high the result register holds; the byte register still
// takes one more byte, and rx_stall rises once both registers are full.
// Reset clears the valid flags of both pipeline registers, restores the default
// configuration (0xAA, 0x55, limit 10) and puts the parser into start-byte search
// with an empty capture.
`default_nettype none

`include "binary_frame_receiver_top_defines.svh"

module binary_frame_receiver_top import bfr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 rx_valid,
	output logic                      rx_stall,
	input  wire logic [7:0]           rx_byte,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output logic                      frame_done,
	output logic                      frame_dropped,
	output logic [7:0]                frame_id,
	output logic [1:0]                request_kind,
	output logic signed [15:0]        speed_value,
	output logic signed [15:0]        radius_value,
	output logic [7:0]                ext_flag,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	cfg_t       cfg;
	res_t       res, res_s2;
	logic       valid_s1, valid_s2;
	logic [7:0] byte_s1;
	logic       s1_open, s2_open, step;

	assign cfg_ready = 1'b1;

	bfr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	assign s2_open  = !valid_s2 || !res_stall;
	assign step     = valid_s1 && s2_open;
	assign s1_open  = !valid_s1 || step;
	assign rx_stall = !s1_open;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_open) valid_s1 <= rx_valid;
			if (s2_open) valid_s2 <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && s1_open) byte_s1 <= rx_byte;
		if (step) res_s2 <= res;
	end

	assign res_valid     = valid_s2;
	assign frame_done    = res_s2.frame_done;
	assign frame_dropped = res_s2.frame_dropped;
	assign frame_id      = res_s2.frame_id;
	assign request_kind  = res_s2.request_kind;
	assign speed_value   = res_s2.speed_value;
	assign radius_value  = res_s2.radius_value;
	assign ext_flag      = res_s2.ext_flag;

	`BFR_ASSERT_IMP(a_done_drop_excl, valid_s2, !(res_s2.frame_done && res_s2.frame_dropped))
	`BFR_ASSERT_IMP(a_decode_only_done, valid_s2 && !res_s2.frame_done, res_s2.request_kind == KIND_OTHER && res_s2.frame_id == 8'd0)
	`BFR_ASSERT_NXT(a_accept_fills_s1, rx_valid && !rx_stall, valid_s1)
	`BFR_ASSERT_IMP(a_stall_only_full, rx_stall, valid_s1 && valid_s2 && res_stall)

endmodule

`default_nettype wire

FILE: tb/sv/tb_binary_frame_receiver_top.sv
`default_nettype none

module tb_binary_frame_receiver_top import bfr_pkg::*;;

	localparam int unsigned ITEM_TARGET    = 1850;
	localparam int unsigned HOLD_CYCLES    = 60;
	localparam int unsigned TAIL_CYCLES    = 4;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic rx_valid = 1'b0;
	logic rx_stall;
	logic [7:0] rx_byte = 8'h00;
	logic res_valid;
	logic res_stall = 1'b0;
	logic frame_done;
	logic frame_dropped;
	logic [7:0] frame_id;
	logic [1:0] request_kind;
	logic signed [15:0] speed_value;
	logic signed [15:0] radius_value;
	logic [7:0] ext_flag;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = 8'h00;

	binary_frame_receiver_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.frame_done(frame_done),
		.frame_dropped(frame_dropped),
		.frame_id(frame_id),
		.request_kind(request_kind),
		.speed_value(speed_value),
		.radius_value(radius_value),
		.ext_flag(ext_flag),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// parser shadow state and register copy
	cfg_t link_cfg;
	phase_t prs_phase;
	logic [3:0] prs_idx;
	logic [7:0] prs_len;
	logic [7:0] prs_id;
	logic [7:0] prs_fields [FIELD_CNT];
	logic prs_first_seen;

	logic [7:0] rx_pending [$];
	res_t parse_results [$];

	int unsigned bytes_queued = 0;
	int unsigned bytes_sent = 0;
	int unsigned beats_checked = 0;
	int unsigned frames_done = 0;
	int unsigned frames_dropped = 0;
	int unsigned kind_seen [4] = '{0, 0, 0, 0};
	int unsigned settings_used = 1;
	int unsigned fail_cnt = 0;
	int unsigned holds_asked = 0;
	bit no_gaps = 1'b0;

	function automatic res_t parse_byte(input logic [7:0] b);
		res_t r;
		logic [3:0] pos;
		r = '0;
		if (prs_phase == PH_CLEAR) begin
			prs_id = '0;
			for (int i = 0; i < FIELD_CNT; i++)
				prs_fields[i] = '0;
			prs_idx = '0;
			prs_first_seen = 1'b0;
			prs_phase = PH_START;
		end
		case (prs_phase)
			PH_START: begin
				if (!prs_first_seen) begin
					if (b == link_cfg.sb_first) begin
						prs_first_seen = 1'b1;
						prs_idx = IDX_AFTER_FIRST;
					end else
						prs_idx = '0;
				end else begin
					// a second first-start byte is a mismatch too
					prs_first_seen = 1'b0;
					if (b == link_cfg.sb_second) begin
						prs_idx = IDX_AFTER_SECOND;
						prs_phase = PH_LEN;
					end else
						prs_idx = '0;
				end
			end
			PH_LEN: begin
				prs_len = b;
				prs_idx = HDR_BYTES;
				prs_phase = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				pos = prs_idx;
				if (pos == POS_ID)
					prs_id = b;
				else if (pos >= POS_FIELD0 && int'(pos) < int'(POS_FIELD0) + FIELD_CNT)
					prs_fields[2'(pos - POS_FIELD0)] = b;
				prs_idx = prs_idx + 4'd1;
				if (prs_len > link_cfg.max_len || prs_len > LEN_CAP) begin
					r.frame_dropped = 1'b1;
					prs_phase = PH_CLEAR;
				end else if (int'(pos) >= int'(prs_len) + int'(HDR_BYTES)) begin
					// payload plus the unchecked checksum byte
					r.frame_done = 1'b1;
					prs_phase = PH_CLEAR;
				end
			end
			default: ;
		endcase
		if (r.frame_done) begin
			r.frame_id = prs_id;
			case (prs_id)
				ID_BASE_CONTROL: begin
					r.request_kind = KIND_BASE_CONTROL;
					r.speed_value = {prs_fields[1], prs_fields[0]};
					r.radius_value = {prs_fields[3], prs_fields[2]};
				end
				ID_CTRL_QUERY: r.request_kind = KIND_CTRL_QUERY;
				ID_EXT_DATA: begin
					r.request_kind = KIND_EXT_DATA;
					r.ext_flag = prs_fields[0];
				end
				default: r.request_kind = KIND_OTHER;
			endcase
		end
		return r;
	endfunction

	// rx driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
		end else begin : drive_rx
			res_t nxt;
			if (rx_valid && !rx_stall) begin
				nxt = parse_byte(rx_byte);
				parse_results.push_back(nxt);
				bytes_sent++;
			end
			if (!rx_valid || !rx_stall) begin
				if (rx_pending.size() != 0 && (no_gaps || $urandom_range(99) >= 22)) begin
					rx_byte <= rx_pending.pop_front();
					rx_valid <= 1'b1;
				end else
					rx_valid <= 1'b0;
			end
		end
	end

	// result monitor
	int unsigned hold_left = 0;
	int unsigned holds_granted = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin : watch_res
			res_t exp;
			if (res_valid && !res_stall) begin
				beats_checked++;
				if (parse_results.size() == 0) begin
					$error("result beat with nothing expected");
					fail_cnt++;
				end else begin
					exp = parse_results.pop_front();
					if (exp.frame_done) begin
						frames_done++;
						kind_seen[exp.request_kind]++;
					end
					if (exp.frame_dropped)
						frames_dropped++;
					if (frame_done !== exp.frame_done) begin
						$error("frame_done: expected %0d, got %0d", exp.frame_done, frame_done);
						fail_cnt++;
					end
					if (frame_dropped !== exp.frame_dropped) begin
						$error("frame_dropped: expected %0d, got %0d",
							exp.frame_dropped, frame_dropped);
						fail_cnt++;
					end
					if (frame_id !== exp.frame_id) begin
						$error("frame_id: expected %0h, got %0h", exp.frame_id, frame_id);
						fail_cnt++;
					end
					if (request_kind !== exp.request_kind) begin
						$error("request_kind: expected %0d, got %0d",
							exp.request_kind, request_kind);
						fail_cnt++;
					end
					if (speed_value !== exp.speed_value) begin
						$error("speed_value: expected %0d, got %0d", exp.speed_value, speed_value);
						fail_cnt++;
					end
					if (radius_value !== exp.radius_value) begin
						$error("radius_value: expected %0d, got %0d",
							exp.radius_value, radius_value);
						fail_cnt++;
					end
					if (ext_flag !== exp.ext_flag) begin
						$error("ext_flag: expected %0h, got %0h", exp.ext_flag, ext_flag);
						fail_cnt++;
					end
				end
			end
			if (holds_granted != holds_asked) begin
				holds_granted <= holds_granted + 1;
				hold_left <= HOLD_CYCLES;
				res_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				res_stall <= 1'b1;
			end else
				res_stall <= !no_gaps && ($urandom_range(99) < 22);
		end
	end

	// watchdog: cycles without any beat on any channel
	int unsigned quiet = 0;

	always @(posedge clk) begin
		if (!arst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall)
				|| (cfg_valid && cfg_ready))
			quiet <= 0;
		else if (quiet >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	task automatic push_byte(input logic [7:0] b);
		rx_pending.push_back(b);
		bytes_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_START_FIRST: link_cfg.sb_first = val;
			CFG_START_SECOND: link_cfg.sb_second = val;
			CFG_MAX_LEN: link_cfg.max_len = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// wait until every byte is sent and every result checked
	task automatic settle();
		do @(negedge clk);
		while (rx_pending.size() != 0 || rx_valid || parse_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// mostly well-formed frames with random content, some noise and broken headers
	task automatic queue_traffic(input int unsigned n);
		int unsigned stop;
		int unsigned pick;
		int unsigned lim;
		int unsigned len;
		int unsigned body;
		stop = bytes_queued + n;
		lim = (link_cfg.max_len < LEN_CAP) ? link_cfg.max_len : LEN_CAP;
		while (bytes_queued < stop) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				push_byte(link_cfg.sb_first);
				push_byte(link_cfg.sb_second);
				pick = $urandom_range(99);
				if (pick < 75)
					len = $urandom_range(lim);
				else if (pick < 90)
					len = $urandom_range(15);
				else
					len = $urandom_range(255);
				push_byte(len[7:0]);
				// oversized frames die on the first payload byte; send only a few
				body = (len > lim) ? 1 + $urandom_range(3) : len;
				for (int i = 0; i < body; i++) begin
					if (i == 0) begin
						case ($urandom_range(3))
							0: push_byte(ID_BASE_CONTROL);
							1: push_byte(ID_CTRL_QUERY);
							2: push_byte(ID_EXT_DATA);
							default: push_byte(8'($urandom_range(255)));
						endcase
					end else
						push_byte(8'($urandom_range(255)));
				end
				if (len <= lim)
					push_byte(8'($urandom_range(255)));
			end else if (pick < 90) begin
				repeat (1 + $urandom_range(3))
					push_byte(8'($urandom_range(255)));
			end else begin
				push_byte(link_cfg.sb_first);
				push_byte($urandom_range(1) ? link_cfg.sb_first : 8'($urandom_range(255)));
			end
		end
	endtask

	initial begin : stim
		logic [7:0] opening [$];
		int unsigned round;
		link_cfg = '{sb_first: START_FIRST_RST, sb_second: START_SECOND_RST,
			max_len: MAX_LEN_RST};
		prs_phase = PH_CLEAR;
		prs_idx = '0;
		prs_len = '0;
		prs_id = '0;
		for (int i = 0; i < FIELD_CNT; i++)
			prs_fields[i] = '0;
		prs_first_seen = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// repeated first start byte, base control at the speed/radius extremes,
		// zero length (checksum lands on the id slot), ext data, oversized drop
		opening = '{START_FIRST_RST, START_FIRST_RST,
			START_FIRST_RST, START_SECOND_RST, 8'h06, ID_BASE_CONTROL, 8'hFF,
			8'h00, 8'h80, 8'hFF, 8'h7F, 8'h5A,
			START_FIRST_RST, START_SECOND_RST, 8'h00, ID_CTRL_QUERY,
			START_FIRST_RST, START_SECOND_RST, 8'h03, ID_EXT_DATA, 8'h00, 8'hFF, 8'hC3,
			START_FIRST_RST, START_SECOND_RST, 8'h0B, ID_BASE_CONTROL};
		foreach (opening[i])
			push_byte(opening[i]);
		settle();

		write_reg(CFG_START_FIRST, 8'h00);
		write_reg(CFG_START_SECOND, 8'hFF);
		write_reg(CFG_MAX_LEN, 8'h00);
		settings_used++;
		@(negedge clk);
		queue_traffic(150);
		settle();

		// limit above the counter bound
		write_reg(CFG_START_FIRST, 8'hFF);
		write_reg(CFG_START_SECOND, 8'h00);
		write_reg(CFG_MAX_LEN, 8'hFF);
		write_reg(CFG_SPARE, 8'($urandom_range(255)));
		settings_used++;
		@(negedge clk);
		queue_traffic(200);
		settle();

		round = 0;
		while (bytes_queued < ITEM_TARGET) begin
			write_reg(CFG_START_FIRST, 8'($urandom_range(255)));
			write_reg(CFG_START_SECOND, 8'($urandom_range(255)));
			case ($urandom_range(9))
				0: write_reg(CFG_MAX_LEN, 8'hFF);
				1: write_reg(CFG_MAX_LEN, 8'($urandom_range(255)));
				default: write_reg(CFG_MAX_LEN, 8'($urandom_range(12)));
			endcase
			settings_used++;
			@(negedge clk);
			no_gaps = (round == 2);
			if (round == 1)
				holds_asked++;
			queue_traffic(220);
			settle();
			round++;
		end
		settle();

		$display("checked %0d result beats for %0d bytes over %0d register settings",
			beats_checked, bytes_sent, settings_used);
		$display("frames: %0d base control, %0d query, %0d ext data, %0d other; %0d dropped",
			kind_seen[KIND_BASE_CONTROL], kind_seen[KIND_CTRL_QUERY],
			kind_seen[KIND_EXT_DATA], kind_seen[KIND_OTHER], frames_dropped);
		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
